// File: hw/rtl/tul_pkg.sv
// shared types, constants and a helper function of the texture unswizzle lookup unit
package tul_pkg;

  // default largest texture side, as log2 of pixels
  localparam int MAX_SIDE_LOG2_DEF = 8;

  // palette geometry
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_ADDR_W      = 8;

  // data words and intermediate address arithmetic
  localparam int WORD_W  = 32;
  localparam int CALC_W  = 32;
  localparam int COORD_W = 8;
  localparam int WIDX_W  = 16;
  localparam int LOG2_W  = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTED    = 2'd2;

  // command codes carried on the input tuser
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_PAL_WR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEX_WR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // read sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEX,
    ST_PAL
  } state_t;

  // place the bits of a coordinate on the even bit positions
  function automatic logic [2*COORD_W-1:0] spread_bits(input logic [COORD_W-1:0] v);
    logic [2*COORD_W-1:0] r;
    r = '0;
    for (int b = 0; b < COORD_W; b++) begin
      r[2*b] = v[b];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/tul_ram.sv
// generic single-port-write, single-port-read ram with registered read-first output
module tul_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-cycle write; rdata holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// File: hw/rtl/tul_addr.sv
// z-order source address and range check for one linear pixel
module tul_addr #(
  parameter int MAX_SIDE_LOG2 = tul_pkg::MAX_SIDE_LOG2_DEF
) (
  input  logic [tul_pkg::LOG2_W-1:0]  width_log2,
  input  logic [tul_pkg::LOG2_W-1:0]  height_log2,
  input  logic [tul_pkg::COORD_W-1:0] pixel_x,
  input  logic [tul_pkg::COORD_W-1:0] pixel_y,
  output logic [2*MAX_SIDE_LOG2-1:0]  addr,
  output logic                        out_of_range
);

  localparam int CW = tul_pkg::CALC_W;
  localparam logic [tul_pkg::LOG2_W-1:0] SideMax = tul_pkg::LOG2_W'(MAX_SIDE_LOG2);

  logic [tul_pkg::LOG2_W-1:0] wl;
  logic [tul_pkg::LOG2_W-1:0] hl;
  logic [tul_pkg::LOG2_W:0]   hl1;
  logic [CW-1:0]              xw;
  logic [CW-1:0]              yw;
  logic [CW-1:0]              wmask;
  logic [CW-1:0]              xmask;
  logic [CW-1:0]              sx;
  logic [CW-1:0]              sy;
  logic [CW-1:0]              sum;

  // saturate the side sizes to the store geometry
  assign wl  = (width_log2 > SideMax) ? SideMax : width_log2;
  assign hl  = (height_log2 > SideMax) ? SideMax : height_log2;
  assign hl1 = {1'b0, hl} + 5'd1;

  assign xw    = CW'(pixel_x);
  assign yw    = CW'(pixel_y);
  assign wmask = (CW'(1) << wl) - CW'(1);
  assign xmask = (CW'(1) << hl1) - CW'(1);

  // range check against the texture sides
  assign out_of_range = (xw >= (CW'(1) << wl)) || (yw >= (CW'(1) << hl));

  // rows: y bits on odd positions, plus one square tile per band of width rows
  assign sy = (CW'(tul_pkg::spread_bits(pixel_y & wmask[tul_pkg::COORD_W-1:0])) << 1)
            + ((yw >> wl) << {wl, 1'b0});

  // columns: x bits on even positions, plus one tile per band of 2*height columns
  assign sx = CW'(tul_pkg::spread_bits(pixel_x & xmask[tul_pkg::COORD_W-1:0]))
            + ((xw >> hl1) << {hl, 1'b1});

  assign sum  = sx + sy;
  assign addr = sum[2*MAX_SIDE_LOG2-1:0];

endmodule

// File: hw/rtl/texture_unswizzle_lookup_unit.sv
// top level of the texture unswizzle lookup unit
//
// One input stream (s_*) carries commands, selected by s_tuser: palette write,
// texel write, or read of a linear pixel (x, y). Only reads give a transaction
// on the output stream (m_*): the ARGB word and an out-of-range flag.
// The configuration port sets width_log2, height_log2 and the paletted mode;
// write it only while no read is in flight.
// A write completes when it is accepted. A read's result enters the output register
// from the texel wait state, or from the palette wait state in paletted mode (texel
// read followed by the dependent palette read); an out-of-range read skips the
// palette read in either mode. The unit takes no new command until the read has
// reached the output register, so a read is finished before the next command is
// taken, and writes run at one per cycle while no read is in flight.
// The output register lets the next command be accepted while a result waits
// to be taken. When the receiver stalls, a finished read waits inside with its
// memory data held, and input is refused until the output register can take it.
// Reset (synchronous, active high) clears the configuration registers, the output
// valid and the control state and holds s_tready low; the texel and palette memories
// are not cleared and must be written before they are read.
module texture_unswizzle_lookup_unit #(
  parameter int MAX_SIDE_LOG2 = tul_pkg::MAX_SIDE_LOG2_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [tul_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tul_pkg::CFG_DATA_W-1:0]   cfg_data,
  // command stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // write_index[15:0], write_value[47:16], pixel_x[55:48], pixel_y[63:56]
  input  logic [63:0]                      s_tdata,
  // cmd[1:0]
  input  logic [tul_pkg::CMD_W-1:0]        s_tuser,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // pixel[31:0]
  output logic [tul_pkg::WORD_W-1:0]       m_tdata,
  // out_of_range[0]
  output logic                             m_tuser
);

  localparam int TexAddrW = 2 * MAX_SIDE_LOG2;
  localparam int TexDepth = 1 << TexAddrW;
  localparam int WW       = tul_pkg::WORD_W;

  // configuration registers
  logic [tul_pkg::LOG2_W-1:0] width_log2;
  logic [tul_pkg::LOG2_W-1:0] height_log2;
  logic                       paletted;

  // command fields
  logic                        accept;
  logic [tul_pkg::WIDX_W-1:0]  write_index;
  logic [WW-1:0]               write_value;
  logic [tul_pkg::COORD_W-1:0] pixel_x;
  logic [tul_pkg::COORD_W-1:0] pixel_y;

  // address path
  logic [TexAddrW-1:0] src_addr;
  logic                src_oor;
  logic                oor;

  // memories
  logic                          tex_we;
  logic                          tex_re;
  logic [WW-1:0]                 tex_rdata;
  logic                          pal_we;
  logic                          pal_re;
  logic [WW-1:0]                 pal_rdata;

  // sequencer
  tul_pkg::state_t state;
  tul_pkg::state_t state_next;
  logic            slot_free;
  logic            out_load;
  logic [WW-1:0]   pixel_next;
  logic            oor_next;

  assign accept      = s_tvalid && s_tready;
  assign write_index = s_tdata[15:0];
  assign write_value = s_tdata[47:16];
  assign pixel_x     = s_tdata[55:48];
  assign pixel_y     = s_tdata[63:56];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2  <= '0;
      height_log2 <= '0;
      paletted    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tul_pkg::CFG_WIDTH_LOG2:  width_log2  <= cfg_data;
        tul_pkg::CFG_HEIGHT_LOG2: height_log2 <= cfg_data;
        tul_pkg::CFG_PALETTED:    paletted    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // linear pixel to swizzled source position
  tul_addr #(
    .MAX_SIDE_LOG2(MAX_SIDE_LOG2)
  ) u_addr (
    .width_log2  (width_log2),
    .height_log2 (height_log2),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .addr        (src_addr),
    .out_of_range(src_oor)
  );

  // texel store
  assign tex_we = accept && (s_tuser == tul_pkg::CMD_TEX_WR);

  tul_ram #(
    .WIDTH(WW),
    .DEPTH(TexDepth)
  ) u_tex_ram (
    .clk  (clk),
    .we   (tex_we),
    .waddr(TexAddrW'(write_index)),
    .wdata(write_value),
    .re   (tex_re),
    .raddr(src_addr),
    .rdata(tex_rdata)
  );

  // palette store
  assign pal_we = accept && (s_tuser == tul_pkg::CMD_PAL_WR);

  tul_ram #(
    .WIDTH(WW),
    .DEPTH(tul_pkg::PALETTE_ENTRIES)
  ) u_pal_ram (
    .clk  (clk),
    .we   (pal_we),
    .waddr(write_index[tul_pkg::PAL_ADDR_W-1:0]),
    .wdata(write_value),
    .re   (pal_re),
    .raddr(tex_rdata[tul_pkg::PAL_ADDR_W-1:0]),
    .rdata(pal_rdata)
  );

  assign slot_free = !m_tvalid || m_tready;

  // range flag of the read in flight
  always_ff @(posedge clk) begin
    if (accept && (s_tuser == tul_pkg::CMD_READ)) begin
      oor <= src_oor;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tul_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tul_pkg::ST_IDLE: begin
        if (accept && (s_tuser == tul_pkg::CMD_READ)) begin
          state_next = tul_pkg::ST_TEX;
        end
      end
      tul_pkg::ST_TEX: begin
        if (oor) begin
          if (slot_free) begin
            state_next = tul_pkg::ST_IDLE;
          end
        end else if (paletted) begin
          state_next = tul_pkg::ST_PAL;
        end else if (slot_free) begin
          state_next = tul_pkg::ST_IDLE;
        end
      end
      tul_pkg::ST_PAL: begin
        if (slot_free) begin
          state_next = tul_pkg::ST_IDLE;
        end
      end
      default: state_next = tul_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready   = 1'b0;
    tex_re     = 1'b0;
    pal_re     = 1'b0;
    out_load   = 1'b0;
    pixel_next = '0;
    oor_next   = 1'b0;
    case (state)
      tul_pkg::ST_IDLE: begin
        s_tready = !rst;
        tex_re   = s_tvalid && (s_tuser == tul_pkg::CMD_READ) && !src_oor;
      end
      tul_pkg::ST_TEX: begin
        if (oor) begin
          out_load = slot_free;
          oor_next = 1'b1;
        end else if (paletted) begin
          pal_re = 1'b1;
        end else begin
          out_load   = slot_free;
          pixel_next = tex_rdata;
        end
      end
      tul_pkg::ST_PAL: begin
        out_load   = slot_free;
        pixel_next = pal_rdata;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= pixel_next;
      m_tuser <= oor_next;
    end
  end

  // a result never overwrites one that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending output");

  // palette lookups happen only in paletted mode and are followed by the palette wait
  assert property (@(posedge clk) disable iff (rst)
    pal_re |-> paletted)
    else $error("palette read outside paletted mode");

  assert property (@(posedge clk) disable iff (rst)
    pal_re |=> (state == tul_pkg::ST_PAL))
    else $error("palette data not awaited after palette read");

  // every accepted read moves on to the texel wait
  assert property (@(posedge clk) disable iff (rst)
    (accept && (s_tuser == tul_pkg::CMD_READ)) |=> (state == tul_pkg::ST_TEX))
    else $error("accepted read not tracked");

  // no texel read while an earlier read is still in flight
  assert property (@(posedge clk) disable iff (rst)
    tex_re |-> (state == tul_pkg::ST_IDLE) && s_tvalid)
    else $error("texel read issued outside a command acceptance");

endmodule

// File: tb/texture_unswizzle_lookup_checker.sv
// checker of the texture unswizzle lookup unit: mirrors its stores and predicts every pixel read
module texture_unswizzle_lookup_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tul_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tul_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // write_index[15:0], write_value[47:16], pixel_x[55:48], pixel_y[63:56]
  input  logic [63:0]                    s_tdata,
  // cmd[1:0]
  input  logic [tul_pkg::CMD_W-1:0]      s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // pixel[31:0]
  input  logic [tul_pkg::WORD_W-1:0]     m_tdata,
  // out_of_range[0]
  input  logic                           m_tuser,
  output int                             errors,
  output int                             pending,
  output int                             reads_checked
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE_MAX    = tul_pkg::MAX_SIDE_LOG2_DEF;
  localparam int TEXEL_DEPTH = 1 << (2 * SIDE_MAX);

  typedef struct packed {
    logic [tul_pkg::WORD_W-1:0] pixel;
    logic                       out_of_range;
  } pixel_result_t;

  // mirrored stores and registers
  logic [tul_pkg::WORD_W-1:0] texel_mem   [0:TEXEL_DEPTH-1];
  logic [tul_pkg::WORD_W-1:0] palette_mem [0:tul_pkg::PALETTE_ENTRIES-1];
  logic [tul_pkg::LOG2_W-1:0] width_cfg;
  logic [tul_pkg::LOG2_W-1:0] height_cfg;
  logic                       pal_mode;

  pixel_result_t         expected_pixels [$];
  pixel_result_t         got;
  pixel_result_t         want;
  int                    err_count;
  int                    checked;

  // place bit b of v at bit 2*b
  function automatic int dilate(input int v);
    int r;
    r = 0;
    for (int b = 0; b < 16; b++) begin
      r |= ((v >> b) & 1) << (2 * b);
    end
    return r;
  endfunction

  // pixel that a read of linear (x, y) returns under the current registers
  function automatic pixel_result_t lookup(input logic [tul_pkg::COORD_W-1:0] px,
                                           input logic [tul_pkg::COORD_W-1:0] py);
    pixel_result_t res;
    int            wl;
    int            hl;
    int            xi;
    int            yi;
    int            sx;
    int            sy;
    logic [15:0]   addr;
    logic [tul_pkg::WORD_W-1:0] texel;
    wl = (int'(width_cfg) > SIDE_MAX) ? SIDE_MAX : int'(width_cfg);
    hl = (int'(height_cfg) > SIDE_MAX) ? SIDE_MAX : int'(height_cfg);
    xi = int'(px);
    yi = int'(py);
    res.pixel = '0;
    res.out_of_range = 1'b1;
    if (xi >= (1 << wl) || yi >= (1 << hl)) begin
      return res;
    end
    // row bands of width rows, width*width words each
    sy = dilate(yi & ((1 << wl) - 1)) << 1;
    sy += (yi >> wl) << (2 * wl);
    // column bands of 2*height columns, 2*height*height words each
    sx = dilate(xi & ((1 << (hl + 1)) - 1));
    sx += (xi >> (hl + 1)) << (2 * hl + 1);
    addr = 16'(sx + sy);
    texel = texel_mem[addr];
    res.pixel = pal_mode ? palette_mem[texel[tul_pkg::PAL_ADDR_W-1:0]] : texel;
    res.out_of_range = 1'b0;
    return res;
  endfunction

  // watch the three ports at every edge
  always @(posedge clk) begin
    if (rst) begin
      width_cfg = '0;
      height_cfg = '0;
      pal_mode = 1'b0;
      expected_pixels.delete();
      err_count = 0;
      checked = 0;
    end else begin
      // result transaction against the oldest prediction
      if (m_tvalid && m_tready) begin
        got.pixel = m_tdata;
        got.out_of_range = m_tuser;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result: expected none actual pixel %h oor %b",
                   $time, got.pixel, got.out_of_range);
          err_count++;
        end else begin
          want = expected_pixels.pop_front();
          checked++;
          if (got.pixel !== want.pixel) begin
            $display("%0t: pixel mismatch: expected %h actual %h",
                     $time, want.pixel, got.pixel);
            err_count++;
          end
          if (got.out_of_range !== want.out_of_range) begin
            $display("%0t: out_of_range mismatch: expected %b actual %b",
                     $time, want.out_of_range, got.out_of_range);
            err_count++;
          end
        end
      end
      // command transaction
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          tul_pkg::CMD_PAL_WR:
            palette_mem[s_tdata[tul_pkg::PAL_ADDR_W-1:0]] = s_tdata[47:16];
          tul_pkg::CMD_TEX_WR: texel_mem[s_tdata[15:0]] = s_tdata[47:16];
          tul_pkg::CMD_READ:
            expected_pixels.push_back(lookup(s_tdata[55:48], s_tdata[63:56]));
          default: ;
        endcase
      end
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          tul_pkg::CFG_WIDTH_LOG2:  width_cfg = cfg_data[tul_pkg::LOG2_W-1:0];
          tul_pkg::CFG_HEIGHT_LOG2: height_cfg = cfg_data[tul_pkg::LOG2_W-1:0];
          tul_pkg::CFG_PALETTED:    pal_mode = cfg_data[0];
          default: ;
        endcase
      end
    end
    errors <= err_count;
    pending <= expected_pixels.size();
    reads_checked <= checked;
  end

endmodule

// File: tb/tb_texture_unswizzle_lookup_unit.sv
// testbench top of the texture unswizzle lookup unit: stimulus, idling and verdict
module tb_texture_unswizzle_lookup_unit;

  timeunit 1ns;
  timeprecision 1ps;

  // the fourth command code does nothing
  localparam logic [tul_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SIDE_MAX     = tul_pkg::MAX_SIDE_LOG2_DEF;
  localparam int TEXEL_DEPTH  = 1 << (2 * SIDE_MAX);
  localparam int NUM_PHASES   = 10;
  localparam int DRAIN_CYCLES = 4;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [tul_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tul_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           s_tvalid;
  logic                           s_tready;
  // write_index[15:0], write_value[47:16], pixel_x[55:48], pixel_y[63:56]
  logic [63:0]                    s_tdata;
  // cmd[1:0]
  logic [tul_pkg::CMD_W-1:0]      s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  // pixel[31:0]
  logic [tul_pkg::WORD_W-1:0]     m_tdata;
  // out_of_range[0]
  logic                           m_tuser;

  int errors;
  int pending;
  int reads_checked;

  // stimulus bookkeeping
  bit steady;
  bit tex_written [TEXEL_DEPTH];
  int cmd_count;
  int side_wl;
  int side_hl;
  int side_w;
  int side_h;

  // register settings per phase, oversized sides included
  int phase_w [NUM_PHASES] = '{1, 8, 8, 3, 6, 0, 2, 12, 4, 15};
  int phase_h [NUM_PHASES] = '{1, 8, 8, 5, 2, 8, 2, 15, 4, 9};
  int phase_p [NUM_PHASES] = '{0, 0, 1, 1, 0, 1, 1, 1, 0, 0};
  int phase_n [NUM_PHASES] = '{100, 120, 120, 150, 130, 100, 130, 100, 130, 100};

  texture_unswizzle_lookup_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  texture_unswizzle_lookup_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .errors        (errors),
    .pending       (pending),
    .reads_checked (reads_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= rst || steady || ($urandom_range(99) >= 12);
  end

  // run limit
  initial begin
    #50000000;
    $display("tb_texture_unswizzle_lookup_unit: errors");
    $finish;
  end

  // place bit b of v at bit 2*b
  function automatic int dilate(input int v);
    int r;
    r = 0;
    for (int b = 0; b < 16; b++) begin
      r |= ((v >> b) & 1) << (2 * b);
    end
    return r;
  endfunction

  // swizzled texel position of an in-range linear (x, y) under the current sides
  function automatic int texel_pos(input int xi, input int yi);
    int sx;
    int sy;
    sy = (dilate(yi & ((1 << side_wl) - 1)) << 1) + ((yi >> side_wl) << (2 * side_wl));
    sx = dilate(xi & ((1 << (side_hl + 1)) - 1))
       + ((xi >> (side_hl + 1)) << (2 * side_hl + 1));
    return (sx + sy) & (TEXEL_DEPTH - 1);
  endfunction

  // one command transaction, with an occasional gap before it
  task automatic send(input logic [tul_pkg::CMD_W-1:0] cmd, input logic [15:0] idx,
                      input logic [31:0] val, input logic [7:0] px,
                      input logic [7:0] py);
    if (!steady && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {py, px, val, idx};
    if (cmd == tul_pkg::CMD_TEX_WR) begin
      tex_written[idx] = 1'b1;
    end
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cmd_count++;
  endtask

  // read of linear (x, y); a texel that was never written gets a write first
  task automatic read_pixel(input logic [7:0] px, input logic [7:0] py);
    int pos;
    if (int'(px) < side_w && int'(py) < side_h) begin
      pos = texel_pos(int'(px), int'(py));
      if (!tex_written[pos]) begin
        send(tul_pkg::CMD_TEX_WR, 16'(pos), $urandom, 8'($urandom), 8'($urandom));
      end
    end
    send(tul_pkg::CMD_READ, 16'($urandom), $urandom, px, py);
  endtask

  // wait until every read has come back and the pipeline is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write sequence, only while idle
  task automatic configure(input int wl, input int hl, input int pal);
    cfg_we <= 1'b1;
    cfg_index <= tul_pkg::CFG_WIDTH_LOG2;
    cfg_data <= tul_pkg::CFG_DATA_W'(wl);
    @(posedge clk);
    cfg_index <= tul_pkg::CFG_HEIGHT_LOG2;
    cfg_data <= tul_pkg::CFG_DATA_W'(hl);
    @(posedge clk);
    cfg_index <= tul_pkg::CFG_PALETTED;
    cfg_data <= {3'($urandom_range(7)), 1'(pal)};
    @(posedge clk);
    cfg_we <= 1'b0;
    side_wl = (wl > SIDE_MAX) ? SIDE_MAX : wl;
    side_hl = (hl > SIDE_MAX) ? SIDE_MAX : hl;
    side_w = 1 << side_wl;
    side_h = 1 << side_hl;
  endtask

  // random mix of reads, writes and unused commands
  task automatic random_items(input int count);
    int stop;
    int r;
    logic [7:0] px;
    logic [7:0] py;
    stop = cmd_count + count;
    while (cmd_count < stop) begin
      r = $urandom_range(99);
      px = 8'($urandom);
      py = 8'($urandom);
      if (r < 55) begin
        if ($urandom_range(99) < 85) begin
          px = 8'($urandom_range(side_w - 1));
          py = 8'($urandom_range(side_h - 1));
        end
        read_pixel(px, py);
      end else if (r < 75) begin
        send(tul_pkg::CMD_TEX_WR, 16'($urandom), $urandom, px, py);
      end else if (r < 90) begin
        send(tul_pkg::CMD_PAL_WR, 16'($urandom), $urandom, px, py);
      end else begin
        send(CMD_UNUSED, 16'($urandom), $urandom, px, py);
      end
    end
  endtask

  // main sequence
  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= CMD_UNUSED;
    m_tready <= 1'b0;
    steady = 1'b0;
    cmd_count = 0;
    side_wl = 0;
    side_hl = 0;
    side_w = 1;
    side_h = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // whole palette first, upper index byte random to exercise the masking
    for (int i = 0; i < tul_pkg::PALETTE_ENTRIES; i++) begin
      send(tul_pkg::CMD_PAL_WR, {8'($urandom), 8'(i)}, $urandom, 8'($urandom),
           8'($urandom));
    end

    // directed checks at the reset geometry of one pixel
    send(tul_pkg::CMD_TEX_WR, 16'h0000, 32'hffff_ffff, 8'hff, 8'hff);
    send(tul_pkg::CMD_READ, 16'hffff, 32'hffff_ffff, 8'h00, 8'h00);
    send(tul_pkg::CMD_TEX_WR, 16'h0000, 32'h0000_0000, 8'h00, 8'h00);
    send(tul_pkg::CMD_READ, 16'h0000, 32'h0000_0000, 8'h00, 8'h00);
    send(tul_pkg::CMD_READ, 16'h0000, 32'h0000_0000, 8'h01, 8'h00);
    send(tul_pkg::CMD_READ, 16'h0000, 32'h0000_0000, 8'h00, 8'h01);
    send(tul_pkg::CMD_READ, 16'hffff, 32'hffff_ffff, 8'hff, 8'hff);
    send(CMD_UNUSED, 16'h0000, 32'h0000_0000, 8'h00, 8'h00);
    send(tul_pkg::CMD_TEX_WR, 16'hffff, 32'h8000_0001, 8'h00, 8'h00);
    send(tul_pkg::CMD_PAL_WR, 16'hab00, 32'h1234_5678, 8'h00, 8'h00);
    send(CMD_UNUSED, 16'hffff, 32'hffff_ffff, 8'hff, 8'hff);
    send(tul_pkg::CMD_READ, 16'h5a5a, 32'ha5a5_a5a5, 8'h00, 8'h00);

    // phases under different register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      steady = (p == 3);
      configure(phase_w[p], phase_h[p], phase_p[p]);
      // corners of the texture and just outside it
      read_pixel(8'h00, 8'h00);
      read_pixel(8'(side_w - 1), 8'(side_h - 1));
      read_pixel(8'(side_w), 8'h00);
      read_pixel(8'h00, 8'(side_h));
      random_items(phase_n[p]);
    end
    steady = 1'b0;
    settle();
    repeat (10) @(posedge clk);

    $display("run: %0d commands over %0d register settings, %0d reads checked",
             cmd_count, NUM_PHASES + 1, reads_checked);
    if (errors == 0) begin
      $display("tb_texture_unswizzle_lookup_unit: clean");
    end else begin
      $display("tb_texture_unswizzle_lookup_unit: errors");
    end
    $finish;
  end

endmodule
